// File: src/pgr_pkg.sv
// ----------------------------------------------------------------------------
// pgr_pkg
// shared types and constants for the pixel grid rect/rotate core
// ----------------------------------------------------------------------------
package pgr_pkg;

    localparam int GRID_WIDTH_DEF  = 50;
    localparam int GRID_HEIGHT_DEF = 6;

    localparam int OP_W       = 2;
    localparam int ARG_W      = 6;
    localparam int COUNT_W    = 9;
    localparam int ROW_BITS_W = 50;
    localparam int LIT_MAX    = 511;

    typedef enum logic [OP_W-1:0] {
        OP_RECT     = 2'd0,
        OP_ROT_ROW  = 2'd1,
        OP_ROT_COL  = 2'd2,
        OP_READ_ROW = 2'd3
    } opcode_t;

    typedef struct packed {
        logic                  valid;
        logic                  bad;
        logic [ROW_BITS_W-1:0] row;
    } meta_t;

endpackage

// File: src/pgr_rotator.sv
// ----------------------------------------------------------------------------
// pgr_rotator
// rotates a line toward higher indexes by an amount taken modulo its length
// ----------------------------------------------------------------------------
module pgr_rotator
    import pgr_pkg::*;
#(
    parameter int WIDTH = GRID_WIDTH_DEF
)
(
    input  logic [WIDTH-1:0] din,
    input  logic [ARG_W-1:0] amount,
    output logic [WIDTH-1:0] dout
);

    logic [ARG_W:0][WIDTH-1:0] stage;

    assign stage[0] = din;

    // each stage turns by a constant power of two reduced modulo the length
    for (genvar i = 0; i < ARG_W; i++)
    begin : g_stage
        localparam int STEP = (1 << i) % WIDTH;
        if (STEP == 0)
        begin : g_none
            assign stage[i+1] = stage[i];
        end
        else
        begin : g_turn
            assign stage[i+1] = amount[i]
                ? {stage[i][WIDTH-STEP-1:0], stage[i][WIDTH-1:WIDTH-STEP]}
                : stage[i];
        end
    end

    assign dout = stage[ARG_W];

endmodule

// File: src/pgr_grid.sv
// ----------------------------------------------------------------------------
// pgr_grid
// command register, grid flops and the combinational grid update
// ----------------------------------------------------------------------------
module pgr_grid
    import pgr_pkg::*;
#(
    parameter int GRID_WIDTH  = GRID_WIDTH_DEF,
    parameter int GRID_HEIGHT = GRID_HEIGHT_DEF
)
(
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   cmd_valid,
    input  logic [OP_W-1:0]                        cmd_op,
    input  logic [ARG_W-1:0]                       cmd_a,
    input  logic [ARG_W-1:0]                       cmd_b,
    output logic [GRID_HEIGHT-1:0][GRID_WIDTH-1:0] grid,
    output meta_t                                  meta
);

    localparam int ROW_IDX_W = $clog2(GRID_HEIGHT);
    localparam int COL_IDX_W = $clog2(GRID_WIDTH);
    localparam logic [ARG_W:0] HEIGHT_LIM = (ARG_W+1)'(GRID_HEIGHT);
    localparam logic [ARG_W:0] WIDTH_LIM  = (ARG_W+1)'(GRID_WIDTH);

    logic                                   valid_reg;
    opcode_t                                op_reg;
    logic [ARG_W-1:0]                       a_reg;
    logic [ARG_W-1:0]                       b_reg;
    logic [GRID_HEIGHT-1:0][GRID_WIDTH-1:0] grid_reg;
    logic [GRID_HEIGHT-1:0][GRID_WIDTH-1:0] grid_next;
    meta_t                                  meta_reg;
    meta_t                                  meta_next;

    logic                   row_ok;
    logic                   col_ok;
    logic [ROW_IDX_W-1:0]   row_idx;
    logic [COL_IDX_W-1:0]   col_idx;
    logic [GRID_WIDTH-1:0]  sel_row;
    logic [GRID_WIDTH-1:0]  rot_row;
    logic [GRID_HEIGHT-1:0] col_bits;
    logic [GRID_HEIGHT-1:0] rot_col;
    logic [GRID_WIDTH-1:0]  rect_mask;
    logic [GRID_HEIGHT-1:0] rect_rows;
    logic [ROW_BITS_W-1:0]  row_wide;

    assign row_ok  = {1'b0, a_reg} < HEIGHT_LIM;
    assign col_ok  = {1'b0, a_reg} < WIDTH_LIM;
    assign row_idx = a_reg[ROW_IDX_W-1:0];
    assign col_idx = a_reg[COL_IDX_W-1:0];
    assign sel_row = grid_reg[row_idx];

    for (genvar r = 0; r < GRID_HEIGHT; r++)
    begin : g_rows
        assign col_bits[r]  = grid_reg[r][col_idx];
        assign rect_rows[r] = b_reg > ARG_W'(r);
    end

    for (genvar c = 0; c < GRID_WIDTH; c++)
    begin : g_cols
        assign rect_mask[c] = a_reg > ARG_W'(c);
    end

    for (genvar i = 0; i < ROW_BITS_W; i++)
    begin : g_wide
        if (i < GRID_WIDTH)
        begin : g_pix
            assign row_wide[i] = sel_row[i];
        end
        else
        begin : g_pad
            assign row_wide[i] = 1'b0;
        end
    end

    pgr_rotator #(.WIDTH(GRID_WIDTH)) u_row_rot
    (
        .din    (sel_row),
        .amount (b_reg),
        .dout   (rot_row)
    );

    pgr_rotator #(.WIDTH(GRID_HEIGHT)) u_col_rot
    (
        .din    (col_bits),
        .amount (b_reg),
        .dout   (rot_col)
    );

    always_comb
    begin
        grid_next = grid_reg;
        meta_next = '0;
        meta_next.valid = valid_reg;
        case (op_reg)
            OP_RECT:
            begin
                for (int r = 0; r < GRID_HEIGHT; r++)
                begin
                    if (rect_rows[r])
                    begin
                        grid_next[r] = grid_reg[r] | rect_mask;
                    end
                end
            end
            OP_ROT_ROW:
            begin
                if (row_ok)
                begin
                    grid_next[row_idx] = rot_row;
                end
                meta_next.bad = !row_ok;
            end
            OP_ROT_COL:
            begin
                if (col_ok)
                begin
                    for (int r = 0; r < GRID_HEIGHT; r++)
                    begin
                        grid_next[r][col_idx] = rot_col[r];
                    end
                end
                meta_next.bad = !col_ok;
            end
            OP_READ_ROW:
            begin
                meta_next.row = row_ok ? row_wide : '0;
                meta_next.bad = !row_ok;
            end
            default:
            begin
                grid_next = grid_reg;
            end
        endcase
        if (!valid_reg)
        begin
            meta_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            grid_reg  <= '0;
            meta_reg  <= '0;
        end
        else
        begin
            valid_reg <= cmd_valid;
            meta_reg  <= meta_next;
            if (valid_reg)
            begin
                grid_reg <= grid_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd_valid)
        begin
            op_reg <= opcode_t'(cmd_op);
            a_reg  <= cmd_a;
            b_reg  <= cmd_b;
        end
    end

    assign grid = grid_reg;
    assign meta = meta_reg;

endmodule

// File: src/pgr_popcount.sv
// ----------------------------------------------------------------------------
// pgr_popcount
// pipelined lit-pixel count: per-row counts, groups of eight rows, total
// ----------------------------------------------------------------------------
module pgr_popcount
    import pgr_pkg::*;
#(
    parameter int GRID_WIDTH  = GRID_WIDTH_DEF,
    parameter int GRID_HEIGHT = GRID_HEIGHT_DEF
)
(
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic [GRID_HEIGHT-1:0][GRID_WIDTH-1:0] grid,
    input  meta_t                                  meta_in,
    output logic [COUNT_W-1:0]                     count,
    output meta_t                                  meta_out
);

    localparam int ROW_CNT_W = $clog2(GRID_WIDTH + 1);
    localparam int NUM_GRP   = (GRID_HEIGHT + 7) / 8;
    localparam int GRP_W     = ROW_CNT_W + 3;
    localparam int TOT_W     = (GRP_W + 3 > COUNT_W + 1) ? GRP_W + 3 : COUNT_W + 1;

    logic [GRID_HEIGHT-1:0][ROW_CNT_W-1:0] row_cnt_reg;
    logic [NUM_GRP-1:0][GRP_W-1:0]         grp_reg;
    logic [NUM_GRP-1:0][GRP_W-1:0]         grp_next;
    logic [TOT_W-1:0]                      total;
    logic [COUNT_W-1:0]                    count_reg;
    meta_t                                 meta1_reg;
    meta_t                                 meta2_reg;
    meta_t                                 meta3_reg;

    always_comb
    begin
        for (int g = 0; g < NUM_GRP; g++)
        begin
            grp_next[g] = '0;
            for (int k = 0; k < 8; k++)
            begin
                if (g * 8 + k < GRID_HEIGHT)
                begin
                    grp_next[g] = grp_next[g] + GRP_W'(row_cnt_reg[g * 8 + k]);
                end
            end
        end
    end

    always_comb
    begin
        total = '0;
        for (int g = 0; g < NUM_GRP; g++)
        begin
            total = total + TOT_W'(grp_reg[g]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            meta1_reg <= '0;
            meta2_reg <= '0;
            meta3_reg <= '0;
        end
        else
        begin
            meta1_reg <= meta_in;
            meta2_reg <= meta1_reg;
            meta3_reg <= meta2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int r = 0; r < GRID_HEIGHT; r++)
        begin
            row_cnt_reg[r] <= ROW_CNT_W'($countones(grid[r]));
        end
        grp_reg   <= grp_next;
        count_reg <= (total > TOT_W'(LIT_MAX)) ? COUNT_W'(LIT_MAX) : COUNT_W'(total);
    end

    assign count    = count_reg;
    assign meta_out = meta3_reg;

endmodule

// File: src/pixel_grid_rect_rotate_core.sv
// ----------------------------------------------------------------------------
// pixel_grid_rect_rotate_core
// one-bit pixel grid with rect fill, row/column rotate and row read-back
//
//   port group   dir  beat marker  contents
//   command      in   start        opcode, arg_a, arg_b
//   result       out  done         lit_count, row_bits, bad_index
//
// one command is taken every cycle; busy stays low
// done rises once the accepted command has passed the command register, the
// grid update register and the row, group and total lit-pixel count stages
// reset clears the grid and empties the pipeline
// results are never stalled; each beat is shown for one cycle
// ----------------------------------------------------------------------------
module pixel_grid_rect_rotate_core
    import pgr_pkg::*;
#(
    parameter int GRID_WIDTH  = GRID_WIDTH_DEF,
    parameter int GRID_HEIGHT = GRID_HEIGHT_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    output logic                  busy,
    input  logic [OP_W-1:0]       opcode,
    input  logic [ARG_W-1:0]      arg_a,
    input  logic [ARG_W-1:0]      arg_b,
    output logic                  done,
    output logic [COUNT_W-1:0]    lit_count,
    output logic [ROW_BITS_W-1:0] row_bits,
    output logic                  bad_index
);

    localparam int LIT_CAP = (GRID_WIDTH * GRID_HEIGHT > LIT_MAX)
                             ? LIT_MAX : GRID_WIDTH * GRID_HEIGHT;

    logic [GRID_HEIGHT-1:0][GRID_WIDTH-1:0] grid;
    meta_t                                  grid_meta;
    meta_t                                  res_meta;
    logic                                   accept;

    assign busy   = 1'b0;
    assign accept = start && !busy;

    pgr_grid #(.GRID_WIDTH(GRID_WIDTH), .GRID_HEIGHT(GRID_HEIGHT)) u_grid
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (accept),
        .cmd_op    (opcode),
        .cmd_a     (arg_a),
        .cmd_b     (arg_b),
        .grid      (grid),
        .meta      (grid_meta)
    );

    pgr_popcount #(.GRID_WIDTH(GRID_WIDTH), .GRID_HEIGHT(GRID_HEIGHT)) u_count
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .grid     (grid),
        .meta_in  (grid_meta),
        .count    (lit_count),
        .meta_out (res_meta)
    );

    assign done      = res_meta.valid;
    assign row_bits  = res_meta.row;
    assign bad_index = res_meta.bad;

    a_accept_to_done: assert property (@(posedge clk) disable iff (!rst_n)
        accept |-> ##5 done)
        else $error("accepted command produced no result beat");

    a_done_from_accept: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(accept, 5))
        else $error("result beat without a matching command");

    a_quiet_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
        !done |-> (!bad_index && row_bits == '0))
        else $error("result payload active outside a beat");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (lit_count <= COUNT_W'(LIT_CAP)))
        else $error("lit count beyond grid size");

    a_bad_no_row: assert property (@(posedge clk) disable iff (!rst_n)
        bad_index |-> (row_bits == '0))
        else $error("row data returned for an out-of-range index");

endmodule

// File: bench/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// self-checking bench for the pixel grid rect/rotate core
//
// commands go in through start/busy with random gaps; a scoreboard keeps its
// own copy of the grid, works out lit count, row read-back and the index flag
// for every accepted beat and checks each done beat against the oldest one.
// a directed opening covers field extremes, clipping, rotate wrap and bad
// indexes; a long random run of mostly in-range rotates and reads follows,
// with sparse small rects so the grid does not saturate early
// ----------------------------------------------------------------------------
import pgr_pkg::*;

typedef struct {
    logic [COUNT_W-1:0]    lit;
    logic [ROW_BITS_W-1:0] row;
    logic                  bad;
} grid_result_t;

class grid_scoreboard;
    localparam int GW = GRID_WIDTH_DEF;
    localparam int GH = GRID_HEIGHT_DEF;

    logic [GW-1:0] grid_rows [GH];
    grid_result_t  expected_beats [$];
    int            errors;

    function new();
        for (int r = 0; r < GH; r++)
            grid_rows[r] = '0;
        errors = 0;
    endfunction

    function int pending();
        return expected_beats.size();
    endfunction

    function grid_result_t apply_command(opcode_t op, logic [ARG_W-1:0] a,
                                         logic [ARG_W-1:0] b);
        grid_result_t  res;
        int            w;
        int            h;
        int            k;
        int            total;
        logic [63:0]   mask;
        logic [GW-1:0] v;
        logic [GH-1:0] col_old;
        res.row = '0;
        res.bad = 1'b0;
        case (op)
            OP_RECT:
            begin
                w = (a > GW) ? GW : int'(a);
                h = (b > GH) ? GH : int'(b);
                mask = (64'd1 << w) - 64'd1;
                for (int r = 0; r < h; r++)
                    grid_rows[r] = grid_rows[r] | mask[GW-1:0];
            end
            OP_ROT_ROW:
            begin
                if (a < GH)
                begin
                    k = int'(b) % GW;
                    v = grid_rows[a];
                    if (k != 0)
                        v = (v << k) | (v >> (GW - k));
                    grid_rows[a] = v;
                end
                else
                    res.bad = 1'b1;
            end
            OP_ROT_COL:
            begin
                if (a < GW)
                begin
                    k = int'(b) % GH;
                    for (int r = 0; r < GH; r++)
                        col_old[r] = grid_rows[r][a];
                    for (int r = 0; r < GH; r++)
                        grid_rows[(r + k) % GH][a] = col_old[r];
                end
                else
                    res.bad = 1'b1;
            end
            default:
            begin
                if (a < GH)
                    res.row = ROW_BITS_W'(grid_rows[a]);
                else
                    res.bad = 1'b1;
            end
        endcase
        total = 0;
        for (int r = 0; r < GH; r++)
            total += $countones(grid_rows[r]);
        res.lit = (total > LIT_MAX) ? COUNT_W'(LIT_MAX) : COUNT_W'(total);
        return res;
    endfunction

    function void note_command(opcode_t op, logic [ARG_W-1:0] a, logic [ARG_W-1:0] b);
        expected_beats.push_back(apply_command(op, a, b));
    endfunction

    function void check_result(logic [COUNT_W-1:0] lit, logic [ROW_BITS_W-1:0] row,
                               logic bad);
        grid_result_t exp_res;
        if (expected_beats.size() == 0)
        begin
            $display("%0t unexpected result beat: expected none, actual lit %0d row %h bad %0d",
                     $time, lit, row, bad);
            errors++;
            return;
        end
        exp_res = expected_beats.pop_front();
        if (lit !== exp_res.lit)
        begin
            $display("%0t lit_count mismatch: expected %0d, actual %0d",
                     $time, exp_res.lit, lit);
            errors++;
        end
        if (row !== exp_res.row)
        begin
            $display("%0t row_bits mismatch: expected %h, actual %h",
                     $time, exp_res.row, row);
            errors++;
        end
        if (bad !== exp_res.bad)
        begin
            $display("%0t bad_index mismatch: expected %0d, actual %0d",
                     $time, exp_res.bad, bad);
            errors++;
        end
    endfunction
endclass

module tb;
    localparam int CYCLE_LIMIT = 400000;
    localparam int RANDOM_CMDS = 2000;

    logic                  clk;
    logic                  rst_n;
    logic                  start;
    logic                  busy;
    logic [OP_W-1:0]       opcode;
    logic [ARG_W-1:0]      arg_a;
    logic [ARG_W-1:0]      arg_b;
    logic                  done;
    logic [COUNT_W-1:0]    lit_count;
    logic [ROW_BITS_W-1:0] row_bits;
    logic                  bad_index;

    grid_scoreboard sb;
    int             cycle_count;
    int             gap_mode;

    pixel_grid_rect_rotate_core u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .opcode    (opcode),
        .arg_a     (arg_a),
        .arg_b     (arg_b),
        .done      (done),
        .lit_count (lit_count),
        .row_bits  (row_bits),
        .bad_index (bad_index)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("tb: FAIL");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (done)
                sb.check_result(lit_count, row_bits, bad_index);
            if (start && !busy)
                sb.note_command(opcode_t'(opcode), arg_a, arg_b);
        end
    end

    function int draw_gap();
        case (gap_mode)
            0:       return 0;
            1:       return $urandom_range(0, 2);
            default: return $urandom_range(0, 16);
        endcase
    endfunction

    task automatic send_cmd(opcode_t op, logic [ARG_W-1:0] a, logic [ARG_W-1:0] b);
        int gap;
        gap = draw_gap();
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start  <= 1'b1;
        opcode <= op;
        arg_a  <= a;
        arg_b  <= b;
        do
            @(posedge clk);
        while (busy);
    endtask

    task automatic wait_results_drained();
        start <= 1'b0;
        @(posedge clk);
        while (sb.pending() != 0)
            @(posedge clk);
    endtask

    task automatic send_random_cmd();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 3)
        begin
            if ($urandom_range(0, 19) == 0)
                send_cmd(OP_RECT, ARG_W'($urandom_range(0, 63)), ARG_W'($urandom_range(0, 1)));
            else
                send_cmd(OP_RECT, ARG_W'($urandom_range(0, 6)), ARG_W'($urandom_range(0, 2)));
        end
        else if (pick < 38)
            send_cmd(OP_ROT_ROW,
                     ARG_W'(($urandom_range(0, 99) < 85) ? $urandom_range(0, 5)
                                                         : $urandom_range(0, 63)),
                     ARG_W'($urandom_range(0, 63)));
        else if (pick < 73)
            send_cmd(OP_ROT_COL,
                     ARG_W'(($urandom_range(0, 99) < 85) ? $urandom_range(0, 49)
                                                         : $urandom_range(0, 63)),
                     ARG_W'($urandom_range(0, 63)));
        else
            send_cmd(OP_READ_ROW,
                     ARG_W'(($urandom_range(0, 99) < 85) ? $urandom_range(0, 5)
                                                         : $urandom_range(0, 63)),
                     ARG_W'($urandom_range(0, 63)));
    endtask

    initial
    begin
        sb          = new();
        cycle_count = 0;
        gap_mode    = 1;
        rst_n       = 1'b0;
        start       = 1'b0;
        opcode      = '0;
        arg_a       = '0;
        arg_b       = '0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed opening
        send_cmd(OP_READ_ROW, 6'd0, 6'd0);
        send_cmd(OP_READ_ROW, 6'd6, 6'd0);
        send_cmd(OP_READ_ROW, 6'd63, 6'd63);
        send_cmd(OP_RECT, 6'd0, 6'd0);
        send_cmd(OP_RECT, 6'd63, 6'd0);
        send_cmd(OP_RECT, 6'd0, 6'd63);
        send_cmd(OP_RECT, 6'd3, 6'd2);
        send_cmd(OP_RECT, 6'd2, 6'd63);
        send_cmd(OP_ROT_ROW, 6'd0, 6'd1);
        send_cmd(OP_ROT_ROW, 6'd0, 6'd50);
        send_cmd(OP_ROT_ROW, 6'd5, 6'd63);
        send_cmd(OP_ROT_ROW, 6'd6, 6'd1);
        send_cmd(OP_ROT_ROW, 6'd63, 6'd5);
        send_cmd(OP_ROT_COL, 6'd0, 6'd1);
        send_cmd(OP_ROT_COL, 6'd49, 6'd6);
        send_cmd(OP_ROT_COL, 6'd1, 6'd0);
        send_cmd(OP_ROT_COL, 6'd2, 6'd63);
        send_cmd(OP_ROT_COL, 6'd50, 6'd1);
        send_cmd(OP_ROT_COL, 6'd63, 6'd2);
        send_cmd(OP_READ_ROW, 6'd0, 6'd0);
        send_cmd(OP_READ_ROW, 6'd5, 6'd0);
        send_cmd(OP_READ_ROW, 6'd1, 6'd63);

        // random run in blocks of differing gap density
        for (int i = 0; i < RANDOM_CMDS; i++)
        begin
            if (i % 100 == 0)
                gap_mode = $urandom_range(0, 2);
            if (i == RANDOM_CMDS / 2)
                wait_results_drained();
            send_random_cmd();
        end

        // full fill with clipping, then a few moves on the saturated grid
        send_cmd(OP_RECT, 6'd63, 6'd1);
        send_cmd(OP_READ_ROW, 6'd0, 6'd0);
        send_cmd(OP_RECT, 6'd63, 6'd63);
        send_cmd(OP_ROT_ROW, 6'd2, 6'd7);
        send_cmd(OP_ROT_COL, 6'd10, 6'd3);
        send_cmd(OP_READ_ROW, 6'd4, 6'd0);
        send_cmd(OP_READ_ROW, 6'd0, 6'd0);

        wait_results_drained();
        repeat (10) @(posedge clk);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("tb: PASS");
        else
            $display("tb: FAIL");
        $finish;
    end
endmodule
